@@ rtl/expm_pkg.sv @@
package expm_pkg;

  // Field and operand widths.
  localparam int WORD_BITS        = 64;
  localparam int OPERAND_WORDS    = 4;
  localparam int FULL_BITS        = WORD_BITS * OPERAND_WORDS;
  localparam int LIMB_BITS        = 32;
  localparam int OPERAND_BITS_DEF = 256;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture base and exponent, set result to one
    logic start_mul;  // begin a truncated multiply pass
    logic sel_sqr;    // with start_mul: square the running base instead of result * base
    logic shift_ex;   // drop the exponent bit just consumed
    logic publish;    // copy the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_done;   // multiply pass finishes and writes back this cycle
    logic ex_zero;    // no exponent bits left to consume
    logic ex_bit;     // current exponent bit
  } status_t;

endpackage

@@ rtl/expm_datapath.sv @@
module expm_datapath #(
  parameter int OPERAND_BITS = expm_pkg::OPERAND_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  expm_pkg::cmd_t                 cmd,
  output expm_pkg::status_t              sts,
  input  logic [expm_pkg::FULL_BITS-1:0] base,
  input  logic [expm_pkg::FULL_BITS-1:0] expo,
  output logic [expm_pkg::FULL_BITS-1:0] power
);

  localparam int LB = expm_pkg::LIMB_BITS;
  localparam int L  = (OPERAND_BITS + LB - 1) / LB;
  localparam int LW = (L > 1) ? $clog2(L) : 1;
  localparam int XW = L * LB;

  // Operand registers.
  logic [OPERAND_BITS-1:0] run;
  logic [OPERAND_BITS-1:0] res;
  logic [OPERAND_BITS-1:0] ex;
  logic                    sqr_sel;

  // Multiplier sequencing and accumulation.
  logic          busy;
  logic          pv;
  logic          last_pv;
  logic [LW-1:0] i_idx;
  logic [LW-1:0] j_idx;
  logic [LW-1:0] j_max;
  logic [LW-1:0] k_pv;
  logic          issue_last;
  logic [2*LB-1:0] prod;
  logic [XW-1:0]   acc;
  logic [XW-1:0]   acc_sum;
  logic [XW-1:0]   a_ext;
  logic [XW-1:0]   b_ext;
  logic [LB-1:0]   a_limb;
  logic [LB-1:0]   b_limb;
  logic [XW+2*LB-1:0] pp_wide;
  logic [XW+2*LB-1:0] pp_shift;
  logic            mul_done;

  // Operand selection: square uses the running base twice.
  assign a_ext  = sqr_sel ? XW'(run) : XW'(res);
  assign b_ext  = XW'(run);
  assign a_limb = a_ext[i_idx*LB +: LB];
  assign b_limb = b_ext[j_idx*LB +: LB];

  // Only limb pairs with i + j below L contribute to the truncated product.
  assign j_max      = LW'(L - 1) - i_idx;
  assign issue_last = (i_idx == LW'(L - 1));

  // Second stage: add the registered partial product at its limb offset.
  assign pp_wide  = {{XW{1'b0}}, prod};
  assign pp_shift = pp_wide << (k_pv * LB);
  assign acc_sum  = acc + pp_shift[XW-1:0];
  assign mul_done = pv && last_pv;

  // Control flags of the multiplier pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      pv      <= 1'b0;
      last_pv <= 1'b0;
    end else begin
      pv      <= busy;
      last_pv <= busy && issue_last;
      if (cmd.start_mul) begin
        busy <= 1'b1;
      end else if (busy && issue_last) begin
        busy <= 1'b0;
      end
    end
  end

  // Limb pair counters and the first stage product.
  always_ff @(posedge clk) begin
    if (cmd.start_mul) begin
      i_idx   <= '0;
      j_idx   <= '0;
      sqr_sel <= cmd.sel_sqr;
    end else if (busy) begin
      if (j_idx == j_max) begin
        i_idx <= i_idx + 1'b1;
        j_idx <= '0;
      end else begin
        j_idx <= j_idx + 1'b1;
      end
    end
    prod <= (2*LB)'(a_limb) * (2*LB)'(b_limb);
    k_pv <= LW'(i_idx + j_idx);
  end

  // Accumulator, cleared at the start of each pass.
  always_ff @(posedge clk) begin
    if (cmd.start_mul) begin
      acc <= '0;
    end else if (pv) begin
      acc <= acc_sum;
    end
  end

  // Operand registers: load, write back products, consume exponent bits.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      run <= base[OPERAND_BITS-1:0];
      ex  <= expo[OPERAND_BITS-1:0];
      res <= OPERAND_BITS'(1);
    end else begin
      if (mul_done) begin
        if (sqr_sel) begin
          run <= acc_sum[OPERAND_BITS-1:0];
        end else begin
          res <= acc_sum[OPERAND_BITS-1:0];
        end
      end
      if (cmd.shift_ex) begin
        ex <= ex >> 1;
      end
    end
  end

  // Output register, zero above the operand width.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      power <= expm_pkg::FULL_BITS'(res);
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.ex_zero  = (ex == '0);
  assign sts.ex_bit   = ex[0];

  // A pass never starts while limb pairs are still being issued.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start_mul |-> !busy)
    else $error("multiply started while the multiplier is busy");

  // The final partial product is the last one in flight.
  a_done_drains: assert property (@(posedge clk) disable iff (rst)
    mul_done |=> !pv)
    else $error("partial product still in flight after the pass ended");

endmodule

@@ rtl/expm_ctrl.sv @@
module expm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  expm_pkg::status_t   sts,
  output expm_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Sequencing of one exponentiation.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.ex_zero) begin
          state_next = S_DONE;
        end else if (sts.ex_bit) begin
          cmd.start_mul = 1'b1;
          state_next    = S_MUL;
        end else begin
          cmd.start_mul = 1'b1;
          cmd.sel_sqr   = 1'b1;
          state_next    = S_SQR;
        end
      end
      S_MUL: begin
        if (sts.mul_done) begin
          cmd.start_mul = 1'b1;
          cmd.sel_sqr   = 1'b1;
          state_next    = S_SQR;
        end
      end
      S_SQR: begin
        if (sts.mul_done) begin
          cmd.shift_ex = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pass completions only arrive while a multiply or square is pending.
  a_done_in_pass: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |-> (state == S_MUL || state == S_SQR))
    else $error("multiply completion outside a pass");

  // A new result never overwrites one that has not been taken.
  a_publish_room: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result published over a pending transaction");

  // A result appears only after the exponent has been fully consumed.
  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("output valid raised outside the finishing state");

endmodule

@@ rtl/exp_mod_2_256.sv @@
// Computes base^exponent modulo 2^OPERAND_BITS by right-to-left square-and-multiply on one
// shared 32x32 multiplier that walks the limb pairs of the truncated product, one pair per
// cycle. A multiply or square walks L*(L+1)/2 limb pairs, with L = ceil(OPERAND_BITS/32)
// (36 pairs at 256 bits). Each exponent bit up to the highest set one costs a scan step,
// one square, and one multiply if the bit is set. One transaction is processed at a time;
// a new one is accepted while the previous result still waits in the output register.
// Input bits above OPERAND_BITS are ignored and result bits above it read as zero.
module exp_mod_2_256 #(
  parameter int OPERAND_BITS = expm_pkg::OPERAND_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [expm_pkg::WORD_BITS-1:0] base_w0,
  input  logic [expm_pkg::WORD_BITS-1:0] base_w1,
  input  logic [expm_pkg::WORD_BITS-1:0] base_w2,
  input  logic [expm_pkg::WORD_BITS-1:0] base_w3,
  input  logic [expm_pkg::WORD_BITS-1:0] exp_w0,
  input  logic [expm_pkg::WORD_BITS-1:0] exp_w1,
  input  logic [expm_pkg::WORD_BITS-1:0] exp_w2,
  input  logic [expm_pkg::WORD_BITS-1:0] exp_w3,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [expm_pkg::WORD_BITS-1:0] power_w0,
  output logic [expm_pkg::WORD_BITS-1:0] power_w1,
  output logic [expm_pkg::WORD_BITS-1:0] power_w2,
  output logic [expm_pkg::WORD_BITS-1:0] power_w3
);

  localparam int WB = expm_pkg::WORD_BITS;

  expm_pkg::cmd_t                 cmd;
  expm_pkg::status_t              sts;
  logic [expm_pkg::FULL_BITS-1:0] power;

  // Controller.
  expm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath with the shared multiplier.
  expm_datapath #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .sts   (sts),
    .base  ({base_w3, base_w2, base_w1, base_w0}),
    .expo  ({exp_w3, exp_w2, exp_w1, exp_w0}),
    .power (power)
  );

  // Split the result into its words.
  assign power_w0 = power[0*WB +: WB];
  assign power_w1 = power[1*WB +: WB];
  assign power_w2 = power[2*WB +: WB];
  assign power_w3 = power[3*WB +: WB];

endmodule
